>>> sv/u16pe_pkg.sv
// Package for the UTF-16 to percent-encoded UTF-8 unit.
// Holds the queue item type, the character-phase enum, constants and the
// UTF-8 / hex helper functions. Depends on nothing.
package u16pe_pkg;

   localparam int unsigned FIFO_DEPTH_DEFAULT = 2;

   localparam logic [15:0] SURR_HI_MIN = 16'hD800;
   localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
   localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
   localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE   = 21'h010000;
   localparam logic [20:0] REPL_CP     = 21'h00FFFD;
   localparam logic [6:0]  CH_PERCENT  = 7'h25;

   // One queued unit of work: an optional flushed U+FFFD, then an optional code point.
   typedef struct packed {
      logic        flush;
      logic        emit;
      logic        last;
      logic [20:0] cp;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [1:0] {
      PH_PCT,
      PH_HI,
      PH_LO
   } phase_type;

   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] n;
      if (cp < 21'h80) begin
         n = 3'd1;
      end else if (cp < 21'h800) begin
         n = 3'd2;
      end else if (cp < 21'h10000) begin
         n = 3'd3;
      end else begin
         n = 3'd4;
      end
      return n;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
      logic [7:0] b;
      logic [2:0] n;
      n = utf8_len(cp);
      b = cp[7:0];
      case (n)
         3'd2: begin
            b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         end
         3'd3: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: b = cp[7:0];
      endcase
      return b;
   endfunction

   // RFC 3986 unreserved set
   function automatic logic is_unreserved(input logic [7:0] b);
      return (b inside {[8'h41:8'h5A]}) || (b inside {[8'h61:8'h7A]}) ||
             (b inside {[8'h30:8'h39]}) || (b inside {8'h2D, 8'h5F, 8'h2E, 8'h7E});
   endfunction

   function automatic logic [6:0] hex_digit(input logic [3:0] nib);
      return (nib < 4'd10) ? (7'h30 + {3'b000, nib}) : (7'h37 + {3'b000, nib});
   endfunction

endpackage

>>> sv/u16pe_ifs.sv
// Channel interfaces of the UTF-16 to percent-encoded UTF-8 unit.
// Valid/ready handshake; an item moves when both are high. No dependencies.
interface u16pe_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        last_unit;

   modport source (output valid, code_unit, last_unit, input ready);
   modport sink   (input valid, code_unit, last_unit, output ready);
endinterface

interface u16pe_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       run_last;
   logic       string_end;

   modport source (output valid, out_char, run_last, string_end, input ready);
   modport sink   (input valid, out_char, run_last, string_end, output ready);
endinterface

>>> sv/utf16_to_utf8_percent_encoder_unit.sv
// UTF-16 to percent-encoded UTF-8 unit: top level.
// Depends on u16pe_pkg, u16pe_ifs, u16pe_front, u16pe_fifo and u16pe_back.
//
// Use: feed UTF-16 code units on req_ch (code_unit, last_unit marking the
// final unit of a string). Each unit yields zero to eighteen ASCII
// characters on rsp_ch, one per item, with run_last on the final character
// of that unit and string_end on the final character of the string.
// A high surrogate is held and yields nothing until its partner arrives;
// surrogates that do not pair up come out as U+FFFD (%EF%BF%BD).
//
// The first character of a unit passes through the queue slot, the back
// end's job register and the output register on its way to rsp_ch.
// Throughput: one character per cycle while rsp_ch is ready, set by the
// back end's single character stage; a unit gives 1 character (unreserved
// ASCII), 3 (other ASCII), up to 18 (flushed U+FFFD and another U+FFFD).
// The front end takes a new unit every cycle while the queue has room.
//
// Reset clears the held surrogate, the queue and the output register.
// When rsp_ch stalls, the output register holds its character, the back
// end waits, the queue fills and req_ch.ready then drops.
module utf16_to_utf8_percent_encoder_unit #(
   parameter int unsigned FIFO_DEPTH = u16pe_pkg::FIFO_DEPTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   u16pe_req_if.sink    req_ch,
   u16pe_rsp_if.source  rsp_ch
);

   u16pe_pkg::q_stat_type q_stat;
   u16pe_pkg::job_type    push_job;
   u16pe_pkg::job_type    head;
   logic                  push;
   logic                  pop;

   // classify units and pair surrogates
   u16pe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_stat   (q_stat),
      .push     (push),
      .push_job (push_job)
   );

   // decouple classification from character expansion
   u16pe_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   // expand each code point into bytes, and each byte into one or three characters
   u16pe_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

>>> sv/u16pe_front.sv
// Front end: accepts code units, pairs surrogates, emits queue items.
// Depends on u16pe_pkg and u16pe_req_if.
module u16pe_front (
   input  logic                  clock,
   input  logic                  reset,
   u16pe_req_if.sink             req_ch,
   input  u16pe_pkg::q_stat_type q_stat,
   output logic                  push,
   output u16pe_pkg::job_type    push_job
);

   logic       pend_ff, pend_in;
   logic [9:0] hi_bits_ff, hi_bits_in;
   logic       is_high, is_low, take;

   assign req_ch.ready = !q_stat.full;
   assign take         = req_ch.valid && req_ch.ready;
   assign is_high      = req_ch.code_unit inside {[u16pe_pkg::SURR_HI_MIN:u16pe_pkg::SURR_HI_MAX]};
   assign is_low       = req_ch.code_unit inside {[u16pe_pkg::SURR_LO_MIN:u16pe_pkg::SURR_LO_MAX]};

   always_comb begin
      pend_in       = pend_ff;
      hi_bits_in    = hi_bits_ff;
      push_job.last = req_ch.last_unit;
      push_job.flush = 1'b0;
      push_job.emit  = 1'b1;
      push_job.cp    = {5'd0, req_ch.code_unit};
      if (pend_ff && is_low) begin
         push_job.cp = u16pe_pkg::SUPP_BASE + {1'b0, hi_bits_ff, req_ch.code_unit[9:0]};
         pend_in     = 1'b0;
      end else begin
         push_job.flush = pend_ff;
         pend_in        = 1'b0;
         if (is_high && !req_ch.last_unit) begin
            // hold the high half until its partner arrives
            push_job.emit = 1'b0;
            pend_in       = 1'b1;
            hi_bits_in    = req_ch.code_unit[9:0];
         end else if (is_high || is_low) begin
            push_job.cp = u16pe_pkg::REPL_CP;
         end
      end
      push = take && (push_job.flush || push_job.emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         hi_bits_ff <= '0;
      end else if (take) begin
         pend_ff    <= pend_in;
         hi_bits_ff <= hi_bits_in;
      end
   end

   a_last_clears_pend: assert property (@(posedge clock) disable iff (reset)
      take && req_ch.last_unit |=> !pend_ff)
      else $error("surrogate still held after end of string");

   a_end_always_pushes: assert property (@(posedge clock) disable iff (reset)
      take && req_ch.last_unit |-> push)
      else $error("end of string produced no queue item");

endmodule

>>> sv/u16pe_fifo.sv
// Short queue between front end and back end.
// Depends on u16pe_pkg.
module u16pe_fifo #(
   parameter int unsigned DEPTH = u16pe_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u16pe_pkg::job_type    push_job,
   input  logic                  pop,
   output u16pe_pkg::job_type    head,
   output u16pe_pkg::q_stat_type q_stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   u16pe_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign head         = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");

endmodule

>>> sv/u16pe_back.sv
// Back end: expands queue items into UTF-8 bytes and percent-encoded characters.
// Depends on u16pe_pkg and u16pe_rsp_if.
module u16pe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  u16pe_pkg::job_type    head,
   input  u16pe_pkg::q_stat_type q_stat,
   output logic                  pop,
   u16pe_rsp_if.source           rsp_ch
);

   logic                 active_ff, active_in;
   u16pe_pkg::job_type   job_ff, job_in;
   logic                 seg_flush_ff, seg_flush_in;
   logic [1:0]           idx_ff, idx_in;
   u16pe_pkg::phase_type phase_ff, phase_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_char_ff, rsp_char_in;
   logic       rsp_run_last_ff, rsp_run_last_in;
   logic       rsp_end_ff, rsp_end_in;

   logic [20:0] cur_cp;
   logic [2:0]  cur_len;
   logic [7:0]  cur_byte;
   logic        safe, byte_done, last_byte, last_seg, final_char, out_free, step;
   logic [6:0]  char_val;

   assign cur_cp     = seg_flush_ff ? u16pe_pkg::REPL_CP : job_ff.cp;
   assign cur_len    = u16pe_pkg::utf8_len(cur_cp);
   assign cur_byte   = u16pe_pkg::utf8_byte(cur_cp, idx_ff);
   assign safe       = u16pe_pkg::is_unreserved(cur_byte);
   assign last_byte  = ({1'b0, idx_ff} == (cur_len - 3'd1));
   assign last_seg   = !seg_flush_ff || !job_ff.emit;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign step       = active_ff && out_free;
   assign pop        = !q_stat.empty && (!active_ff || (step && final_char));

   // character of the current phase
   always_comb begin
      byte_done = safe;
      char_val  = cur_byte[6:0];
      if (!safe) begin
         case (phase_ff)
            u16pe_pkg::PH_PCT: char_val = u16pe_pkg::CH_PERCENT;
            u16pe_pkg::PH_HI:  char_val = u16pe_pkg::hex_digit(cur_byte[7:4]);
            u16pe_pkg::PH_LO: begin
               char_val  = u16pe_pkg::hex_digit(cur_byte[3:0]);
               byte_done = 1'b1;
            end
            default:           char_val = u16pe_pkg::CH_PERCENT;
         endcase
      end
      final_char = byte_done && last_byte && last_seg;
   end

   // next phase, byte and segment
   always_comb begin
      active_in    = active_ff;
      job_in       = job_ff;
      seg_flush_in = seg_flush_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      if (step) begin
         if (!byte_done) begin
            case (phase_ff)
               u16pe_pkg::PH_PCT: phase_in = u16pe_pkg::PH_HI;
               u16pe_pkg::PH_HI:  phase_in = u16pe_pkg::PH_LO;
               default:           phase_in = u16pe_pkg::PH_PCT;
            endcase
         end else begin
            phase_in = u16pe_pkg::PH_PCT;
            if (!last_byte) begin
               idx_in = idx_ff + 2'd1;
            end else if (!last_seg) begin
               seg_flush_in = 1'b0;
               idx_in       = 2'd0;
            end else begin
               active_in = 1'b0;
            end
         end
      end
      if (pop) begin
         active_in    = 1'b1;
         job_in       = head;
         seg_flush_in = head.flush;
         idx_in       = 2'd0;
         phase_in     = u16pe_pkg::PH_PCT;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_char_in     = rsp_char_ff;
      rsp_run_last_in = rsp_run_last_ff;
      rsp_end_in      = rsp_end_ff;
      if (step) begin
         rsp_valid_in    = 1'b1;
         rsp_char_in     = char_val;
         rsp_run_last_in = final_char;
         rsp_end_in      = final_char && job_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= u16pe_pkg::PH_PCT;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff          <= job_in;
      seg_flush_ff    <= seg_flush_in;
      idx_ff          <= idx_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_run_last_ff <= rsp_run_last_in;
      rsp_end_ff      <= rsp_end_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_char   = rsp_char_ff;
   assign rsp_ch.run_last   = rsp_run_last_ff;
   assign rsp_ch.string_end = rsp_end_ff;

   a_cp_seg_has_cp: assert property (@(posedge clock) disable iff (reset)
      active_ff && !seg_flush_ff |-> job_ff.emit)
      else $error("code point segment without a code point");

   a_end_on_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_ff |-> rsp_run_last_ff)
      else $error("string end not on the last character of a run");

endmodule
